>>> sv/upd_pkg.sv
// Shared types, character constants and hex-digit helper for the URI percent decoder.
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] CaseBit   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [3:0] HexLetterBase = 4'd10;

  typedef enum logic [2:0] {
    MODE_USUAL       = 3'b001,
    MODE_AFTER_PCT   = 3'b010,
    MODE_AFTER_DIGIT = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] nibble;
  } upd_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } upd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(logic [7:0] b);
    hex_t       h;
    logic [7:0] low;
    logic [7:0] diff;
    h   = '0;
    low = b | CaseBit;
    if (b inside {[8'h30:8'h39]}) begin
      diff  = b - ChZero;
      h.ok  = 1'b1;
      h.val = diff[3:0];
    end else if (low inside {[8'h61:8'h66]}) begin
      diff  = low - ChLowA;
      h.ok  = 1'b1;
      h.val = diff[3:0] + HexLetterBase;
    end
    return h;
  endfunction

endpackage

>>> sv/upd_step.sv
// Per-byte decode step: next mode, held nibble and result for one input byte.
module upd_step (
  input  upd_pkg::mode_e     mode_i,
  input  logic [3:0]         nibble_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output upd_pkg::upd_res_t  res_o,
  output upd_pkg::upd_state_t next_o
);

  upd_pkg::hex_t hex;

  assign hex = upd_pkg::hex_value(byte_i);

  always_comb begin
    res_o.valid = 1'b0;
    res_o.data  = 8'h00;
    res_o.last  = last_i;
    next_o.mode   = mode_i;
    next_o.nibble = nibble_i;
    case (mode_i)
      upd_pkg::MODE_USUAL: begin
        if (byte_i == upd_pkg::ChPercent) begin
          next_o.mode = upd_pkg::MODE_AFTER_PCT;
        end else begin
          res_o.valid = 1'b1;
          res_o.data  = (byte_i == upd_pkg::ChPlus) ? upd_pkg::ChSpace : byte_i;
        end
      end
      upd_pkg::MODE_AFTER_PCT: begin
        if (hex.ok) begin
          next_o.nibble = hex.val;
          next_o.mode   = upd_pkg::MODE_AFTER_DIGIT;
        end else begin
          next_o.mode = upd_pkg::MODE_USUAL;
          res_o.valid = 1'b1;
          res_o.data  = byte_i;
        end
      end
      default: begin
        next_o.mode = upd_pkg::MODE_USUAL;
        if (hex.ok) begin
          res_o.valid = 1'b1;
          res_o.data  = {nibble_i, hex.val};
        end
      end
    endcase
    if (last_i) begin
      next_o.mode   = upd_pkg::MODE_USUAL;
      next_o.nibble = 4'h0;
    end
  end

endmodule

>>> sv/uri_percent_decoder.sv
// URI percent decoder top level: input register, decode step, output register.
// Decodes one byte per transfer, one result per input byte, one byte per clock
// sustained while the master side does not stall. Each input byte passes
// through one input register, the decode step, and one output register before
// its result appears on the master side. The result register frees in the
// same cycle it is taken, so both sides may stream without gaps. tuser on the
// master side flags whether tdata carries a decoded byte; tdata is zero when it
// does not. tlast follows the input byte's tlast, and the escape state is
// cleared at every tlast.
module uri_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] out_valid
  output logic       m_axis_tlast
);

  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_last_q;
  upd_pkg::upd_state_t st_q;
  upd_pkg::upd_state_t st_d;
  upd_pkg::upd_res_t   res_d;
  upd_pkg::upd_res_t   res_q;
  logic                m_valid_q;
  logic                out_free;
  logic                adv;
  logic                s_accept;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign adv           = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  upd_step u_step (
    .mode_i   (st_q.mode),
    .nibble_i (st_q.nibble),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .res_o    (res_d),
    .next_o   (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      st_q.mode   <= upd_pkg::MODE_USUAL;
      st_q.nibble <= 4'h0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        m_valid_q <= s1_valid_q;
      end
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_byte_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q.data;
  assign m_axis_tuser  = res_q.valid;
  assign m_axis_tlast  = res_q.last;

endmodule

>>> sv/upd_checker.sv
// Port-level checks for the URI percent decoder, bound to the top level.
module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  logic [1:0] pend_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
      && $stable(s_axis_tlast))
    else $error("input changed while waiting");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'h00)
    else $error("data not zero without decoded byte");

  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two transfers in flight");

  a_nofull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while full");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);
